/* hdl/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// trigger in one cycle implies outcome in the next
`define ASSERT_NEXT(label, trig, outcome, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (outcome)) \
		else $error(msg);

`endif

/* hdl/wans_pkg.sv */
// Types, codes and helper functions of the weekly alarm scheduler.
// No dependencies; used by wans_ctrl, wans_dp and the top level.
`timescale 1ns / 1ps

package wans_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_FIRE   = 2'd3;

	localparam logic [2:0] ST_DONE  = 3'd0;
	localparam logic [2:0] ST_HIT   = 3'd1;
	localparam logic [2:0] ST_NONE  = 3'd2;
	localparam logic [2:0] ST_FIRED = 3'd3;
	localparam logic [2:0] ST_MISS  = 3'd4;

	localparam logic [26:0] MAX_TOD = 27'd86399999;
	localparam logic [29:0] DAY_MS  = 30'd86400000;

	typedef struct packed {
		logic [15:0] router;
		logic [26:0] time_ms;
		logic [6:0]  days;
		logic [15:0] destination;
		logic [15:0] source;
	} entry_t;

	typedef struct packed {
		logic load;
		logic wr_entry;
		logic rm_entry;
		logic emit_done;
		logic fire_rd;
		logic emit_fire;
		logic q_start;
		logic p2_start;
		logic issue;
		logic pass2;
		logic emit_none;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pipe_busy;
		logic found;
	} sts_t;

	// weekday 1..7 (0 as Sunday) to index 0 Monday .. 6 Sunday
	function automatic logic [2:0] day_index(input logic [2:0] d);
		logic [2:0] r;
		unique case (d)
			3'd1: r = 3'd0;
			3'd2: r = 3'd1;
			3'd3: r = 3'd2;
			3'd4: r = 3'd3;
			3'd5: r = 3'd4;
			3'd6: r = 3'd5;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

	function automatic logic [26:0] sat_tod(input logic [26:0] t);
		return (t > MAX_TOD) ? MAX_TOD : t;
	endfunction

	// bit i of result is weekday (today + i) mod 7
	function automatic logic [6:0] rot_days(input logic [6:0] days, input logic [2:0] today);
		logic [6:0] r;
		logic [3:0] j;
		for (int i = 0; i < 7; i++) begin
			j = 4'(today) + 4'(i);
			if (j >= 4'd7) begin
				j = j - 4'd7;
			end
			r[i] = days[j[2:0]];
		end
		return r;
	endfunction

	function automatic logic [29:0] kday_ms(input logic [2:0] k);
		return 30'(k) * DAY_MS;
	endfunction

endpackage

/* hdl/wans_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wans_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/wans_ctrl.sv */
// Controller of the scheduler: sequences edits, fire and the two query scans.
// Depends on wans_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wans_ctrl
	import wans_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	output logic       busy,
	output cmd_t       cmd,
	input  sts_t       sts
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FIRE   = 3'd1;
	localparam logic [2:0] S_SCAN1  = 3'd2;
	localparam logic [2:0] S_DRAIN1 = 3'd3;
	localparam logic [2:0] S_SCAN2  = 3'd4;
	localparam logic [2:0] S_DRAIN2 = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (mode)
						MODE_WRITE: begin
							cmd.wr_entry  = 1'b1;
							cmd.emit_done = 1'b1;
						end
						MODE_REMOVE: begin
							cmd.rm_entry  = 1'b1;
							cmd.emit_done = 1'b1;
						end
						MODE_QUERY: begin
							cmd.q_start = 1'b1;
							state_d     = S_SCAN1;
						end
						default: begin
							cmd.fire_rd = 1'b1;
							state_d     = S_FIRE;
						end
					endcase
				end
			end
			S_FIRE: begin
				cmd.emit_fire = 1'b1;
				state_d       = S_IDLE;
			end
			S_SCAN1: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN1;
				end
			end
			S_DRAIN1: begin
				if (!sts.pipe_busy) begin
					if (sts.found) begin
						cmd.p2_start = 1'b1;
						state_d      = S_SCAN2;
					end else begin
						cmd.emit_none = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			S_SCAN2: begin
				cmd.issue = 1'b1;
				cmd.pass2 = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN2;
				end
			end
			S_DRAIN2: begin
				cmd.pass2 = 1'b1;
				if (!sts.pipe_busy) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`ASSERT_ALWAYS(a_one_emit, $onehot0({cmd.emit_done, cmd.emit_fire, cmd.emit_none, cmd.flush}), "more than one result command")
	`ASSERT_NEXT(a_query_holds, start && !busy && mode == MODE_QUERY, busy && !cmd.flush, "query accepted without scan")
	`ASSERT_ALWAYS(a_issue_scan, !(cmd.issue && cmd.fire_rd), "scan read collides with fire read")

endmodule

/* hdl/wans_dp.sv */
// Datapath of the scheduler: valid bits, scan pipeline, minimum tracking,
// pending hit and result register. Depends on wans_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wans_dp
	import wans_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [3:0]       entry_id,
	input  logic [15:0]      router,
	input  logic [26:0]      time_ms,
	input  logic [6:0]       day_mask,
	input  logic [15:0]      destination,
	input  logic [15:0]      source,
	input  logic [2:0]       now_day,
	input  logic [26:0]      now_ms,
	output logic             ram_we,
	output logic [IDX_W-1:0] ram_waddr,
	output entry_t           ram_wdata,
	output logic             ram_re,
	output logic [IDX_W-1:0] ram_raddr,
	input  entry_t           ram_rdata,
	output logic             strobe,
	output logic [2:0]       status,
	output logic [3:0]       hit_id,
	output logic [15:0]      out_router,
	output logic [15:0]      out_destination,
	output logic [15:0]      out_source,
	output logic [29:0]      interval_ms,
	output logic             last
);

	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               found_q;
	logic [29:0]        best_q;
	logic               pend_v_q;
	logic [IDX_W-1:0]   pend_id_q;
	logic [29:0]        pend_iv_q;

	logic [15:0]        router_q;
	logic [2:0]         today_q;
	logic [26:0]        now_q;
	logic [3:0]         id_q;
	logic               fire_ok_q;

	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               vb_s1;
	logic               v_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               elig_s2;
	logic [29:0]        iv_s2;

	logic               strobe_q;
	logic [2:0]         status_q;
	logic [3:0]         hit_id_q;
	logic [15:0]        router_o_q;
	logic [15:0]        dest_o_q;
	logic [15:0]        src_o_q;
	logic [29:0]        iv_o_q;
	logic               last_q;

	logic [2:0]         status_d;
	logic [3:0]         hit_id_d;
	logic [15:0]        router_o_d;
	logic [15:0]        dest_o_d;
	logic [15:0]        src_o_d;
	logic [29:0]        iv_o_d;
	logic               last_d;

	logic               id_in_range;
	logic [IDX_W-1:0]   id_idx;
	logic [6:0]         rot;
	logic               due_today;
	logic [2:0]         k_days;
	logic [29:0]        base_ms;
	logic [29:0]        iv_d;
	logic               elig_d;
	logic               p1_take;
	logic               p2_hit;
	logic               fired;

	assign id_in_range = (32'(entry_id) < ENTRIES);
	assign id_idx      = IDX_W'(entry_id);

	assign ram_we                = cmd.wr_entry && id_in_range;
	assign ram_waddr             = id_idx;
	assign ram_wdata.router      = router;
	assign ram_wdata.time_ms     = sat_tod(time_ms);
	assign ram_wdata.days        = day_mask;
	assign ram_wdata.destination = destination;
	assign ram_wdata.source      = source;
	assign ram_re                = cmd.issue || cmd.fire_rd;
	assign ram_raddr             = cmd.fire_rd ? id_idx : cnt_q;

	// next run of the entry now leaving the RAM
	always_comb begin
		rot       = rot_days(ram_rdata.days, today_q);
		due_today = rot[0] && (now_q < ram_rdata.time_ms);
		k_days    = 3'd7;
		for (int i = 6; i >= 1; i--) begin
			if (rot[i]) begin
				k_days = 3'(i);
			end
		end
		base_ms = due_today ? 30'd0 : kday_ms(k_days);
		iv_d    = base_ms + 30'(ram_rdata.time_ms) - 30'(now_q);
		elig_d  = vb_s1 && (ram_rdata.router == router_q) && (ram_rdata.days != 7'd0);
	end

	assign p1_take = v_s2 && elig_s2 && !cmd.pass2 && (!found_q || iv_s2 < best_q);
	assign p2_hit  = v_s2 && elig_s2 && cmd.pass2 && (iv_s2 == best_q);
	assign fired   = fire_ok_q && ram_rdata.days[today_q];

	always_comb begin
		status_d   = ST_DONE;
		hit_id_d   = '0;
		router_o_d = '0;
		dest_o_d   = '0;
		src_o_d    = '0;
		iv_o_d     = '0;
		last_d     = 1'b1;
		priority if (cmd.emit_none) begin
			status_d = ST_NONE;
		end else if (cmd.emit_fire) begin
			if (fired) begin
				status_d   = ST_FIRED;
				hit_id_d   = id_q;
				router_o_d = ram_rdata.router;
				dest_o_d   = ram_rdata.destination;
				src_o_d    = ram_rdata.source;
			end else begin
				status_d = ST_MISS;
			end
		end else if (cmd.flush || (p2_hit && pend_v_q)) begin
			status_d = ST_HIT;
			hit_id_d = 4'(pend_id_q);
			iv_o_d   = pend_iv_q;
			last_d   = cmd.flush;
		end else begin
			status_d = ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			pend_v_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.wr_entry && id_in_range) begin
				valid_q[id_idx] <= 1'b1;
			end
			if (cmd.rm_entry && id_in_range) begin
				valid_q[id_idx] <= 1'b0;
			end
			if (cmd.q_start || cmd.p2_start) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.q_start) begin
				found_q <= 1'b0;
			end else if (p1_take) begin
				found_q <= 1'b1;
				best_q  <= iv_s2;
			end
			if (cmd.p2_start || cmd.flush) begin
				pend_v_q <= 1'b0;
			end else if (p2_hit) begin
				pend_v_q <= 1'b1;
			end
			v_s1     <= cmd.issue;
			v_s2     <= v_s1;
			strobe_q <= cmd.emit_done || cmd.emit_none || cmd.emit_fire || cmd.flush ||
				(p2_hit && pend_v_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			router_q <= router;
			today_q  <= day_index(now_day);
			now_q    <= sat_tod(now_ms);
			id_q     <= entry_id;
		end
		if (cmd.fire_rd) begin
			fire_ok_q <= id_in_range && valid_q[id_idx];
		end
		idx_s1  <= cnt_q;
		vb_s1   <= valid_q[cnt_q];
		idx_s2  <= idx_s1;
		elig_s2 <= elig_d;
		iv_s2   <= iv_d;
		if (p2_hit) begin
			pend_id_q <= idx_s2;
			pend_iv_q <= iv_s2;
		end

		status_q   <= status_d;
		hit_id_q   <= hit_id_d;
		router_o_q <= router_o_d;
		dest_o_q   <= dest_o_d;
		src_o_q    <= src_o_d;
		iv_o_q     <= iv_o_d;
		last_q     <= last_d;
	end

	assign sts.scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.found     = found_q;

	assign strobe          = strobe_q;
	assign status          = status_q;
	assign hit_id          = hit_id_q;
	assign out_router      = router_o_q;
	assign out_destination = dest_o_q;
	assign out_source      = src_o_q;
	assign interval_ms     = iv_o_q;
	assign last            = last_q;

	`ASSERT_ALWAYS(a_hit_is_best, !(strobe_q && status_q == ST_HIT) || iv_o_q == best_q, "query hit interval differs from minimum")
	`ASSERT_NEXT(a_none_not_found, cmd.emit_none, strobe_q && !found_q, "none result with a hit recorded")
	`ASSERT_ALWAYS(a_flush_pending, !cmd.flush || pend_v_q, "query flush without pending hit")

endmodule

/* hdl/weekly_alarm_next_due_scheduler.sv */
// Top level of the weekly alarm next-due scheduler.
// Depends on wans_pkg, wans_ctrl, wans_dp and wans_ram.
//
//   channel   handshake          payload
//   command   start / busy       mode, entry_id, router, time_ms, day_mask,
//                                destination, source, now_day, now_ms
//   result    strobe (1 cycle)   status, hit_id, out_router, out_destination,
//                                out_source, interval_ms, last
//
// Write and remove: result in the cycle after the accept, busy stays low.
// Fire: one RAM read, then the result is registered from the read data in S_FIRE.
// Query: a minimum scan and, only with a hit, a second scan that reports the matches,
// both through the single RAM read port; busy stays high while the scans run.
// Reset clears the valid bits and control; entry data is undefined until written.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps

module weekly_alarm_next_due_scheduler
	import wans_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [3:0]  entry_id,
	input  logic [15:0] router,
	input  logic [26:0] time_ms,
	input  logic [6:0]  day_mask,
	input  logic [15:0] destination,
	input  logic [15:0] source,
	input  logic [2:0]  now_day,
	input  logic [26:0] now_ms,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [3:0]  hit_id,
	output logic [15:0] out_router,
	output logic [15:0] out_destination,
	output logic [15:0] out_source,
	output logic [29:0] interval_ms,
	output logic        last
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	cmd_t             cmd;
	sts_t             sts;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	wans_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	wans_dp #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.entry_id        (entry_id),
		.router          (router),
		.time_ms         (time_ms),
		.day_mask        (day_mask),
		.destination     (destination),
		.source          (source),
		.now_day         (now_day),
		.now_ms          (now_ms),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.strobe          (strobe),
		.status          (status),
		.hit_id          (hit_id),
		.out_router      (out_router),
		.out_destination (out_destination),
		.out_source      (out_source),
		.interval_ms     (interval_ms),
		.last            (last)
	);

	wans_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
